// File: rtl/tld_pkg.sv
package tld_pkg;
  localparam int QueueDepthDefault = 1024;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActPop   = 2'd1,
    ActFlush = 2'd2,
    ActNone  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SigNone = 2'd0,
    SigIntr = 2'd1,
    SigQuit = 2'd2,
    SigSusp = 2'd3
  } sig_t;

  typedef enum logic [2:0] {
    RegMode  = 3'd0,
    RegSig   = 3'd1,
    RegEdit  = 3'd2,
    RegEol   = 3'd3,
    RegGroup = 3'd4
  } reg_t;

  // Byte class decided by the datapath for a host write.
  typedef enum logic [2:0] {
    ClsSignal, ClsRaw, ClsErase, ClsKill, ClsEof, ClsStore, ClsStoreCommit
  } cls_t;

  typedef struct packed {
    logic load;     // capture the input beat
    logic apply;    // apply single-cycle update for the captured item
    logic pop_rd;   // issue queue read
    logic copy_rd;  // read line store at copy index
    logic copy_wr;  // push copied byte
    logic copy_end; // clear line, finish copy
    logic finish;   // latch result
  } cmd_t;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] action;
    logic       line_empty;
    logic       copy_last;
  } stat_t;
endpackage

// File: rtl/terminal_line_discipline.sv
// Sequence: an input beat goes through Apply and Finish to its result beat for pop, write
//   and empty commits; a line commit adds CopyRd and CopyWr per byte of the pending line
//   (line store read, then queue write); a flush of an empty line holding a delimiter
//   byte adds CopyRd. Flow: one item at a time; the next beat is accepted in the cycle
//   the previous result beat leaves.
// Reset: synchronous, active high; clears pointers, counts and control state,
//   loads register reset values; queue and line store contents stay undefined.
module terminal_line_discipline import tld_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_byte[7:0], signal_group[39:8], queued_count[49:40], line_length[59:50], zero above
  output logic [63:0] m_tdata,
  output logic [2:0]  m_tuser,   // read_valid[0], signal_kind[2:1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  mode_flags;
  logic [23:0] signal_chars, edit_chars;
  logic [7:0]  eol_char;
  logic [31:0] foreground_group;
  logic [2:0]  reg_idx;
  cmd_t        cmd;
  stat_t       stat;
  logic [7:0]  read_byte;
  logic        read_valid;
  logic [1:0]  signal_kind;
  logic [31:0] signal_group;
  logic [9:0]  queued_count, line_length;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register file: written on the access cycle of an APB write.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags <= 3'd7;
      signal_chars <= 24'h1A1C03;
      edit_chars <= 24'h04157F;
      eol_char <= 8'd0;
      foreground_group <= 32'd0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegMode:  mode_flags <= pwdata[2:0];
        RegSig:   signal_chars <= pwdata[23:0];
        RegEdit:  edit_chars <= pwdata[23:0];
        RegEol:   eol_char <= pwdata[7:0];
        RegGroup: foreground_group <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      RegMode:  prdata = {29'd0, mode_flags};
      RegSig:   prdata = {8'd0, signal_chars};
      RegEdit:  prdata = {8'd0, edit_chars};
      RegEol:   prdata = {24'd0, eol_char};
      RegGroup: prdata = foreground_group;
      default: ;
    endcase
  end

  tld_controller u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .stat, .cmd
  );

  tld_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_action(s_tuser), .in_byte(s_tdata),
    .mode_flags, .signal_chars, .edit_chars, .eol_char, .foreground_group,
    .read_byte, .read_valid, .signal_kind, .signal_group,
    .queued_count, .line_length
  );

  assign m_tdata = {4'd0, line_length, queued_count, signal_group, read_byte};
  assign m_tuser = {signal_kind, read_valid};
endmodule

// File: rtl/tld_datapath.sv
module tld_datapath import tld_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte,
  input  logic [2:0]  mode_flags,
  input  logic [23:0] signal_chars,
  input  logic [23:0] edit_chars,
  input  logic [7:0]  eol_char,
  input  logic [31:0] foreground_group,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic [1:0]  signal_kind,
  output logic [31:0] signal_group,
  output logic [9:0]  queued_count,
  output logic [9:0]  line_length
);
  localparam int AW = $clog2(QUEUE_DEPTH);

  // Advance a ring pointer, wrapping at the queue depth.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [7:0]    queue_mem [QUEUE_DEPTH];
  logic [7:0]    line_mem  [QUEUE_DEPTH];
  logic [AW-1:0] head, tail, line_cnt, copy_idx;
  logic [1:0]    act;
  logic [7:0]    byte_r, b, qdata, ldata;
  logic [1:0]    kind, kind_r;
  logic          popped;
  cls_t          cls;

  assign b = (byte_r == ChCr && mode_flags[0]) ? ChLf : byte_r;

  always_comb begin
    kind = SigNone;
    if (b == signal_chars[7:0]) kind = SigIntr;
    else if (b == signal_chars[23:16]) kind = SigSusp;
    else if (b == signal_chars[15:8]) kind = SigQuit;
    if (mode_flags[1] && kind != SigNone) cls = ClsSignal;
    else if (!mode_flags[2]) cls = ClsRaw;
    else if (b == edit_chars[7:0]) cls = ClsErase;
    else if (b == edit_chars[15:8]) cls = ClsKill;
    else if (b == edit_chars[23:16]) cls = ClsEof;
    else if (b == ChLf || (eol_char != 8'd0 && b == eol_char)) cls = ClsStoreCommit;
    else cls = ClsStore;
  end

  assign stat.cls = cls;
  assign stat.action = act;
  assign stat.line_empty = (line_cnt == '0);
  assign stat.copy_last = (copy_idx + AW'(1) == line_cnt);

  logic [AW-1:0] head_inc;
  logic          push_en;
  logic [7:0]    push_data;
  logic [AW:0]   used;
  assign head_inc = ptr_inc(head);
  assign used = (head >= tail) ? {1'b0, head - tail}
                               : {1'b0, head} + (AW+1)'(QUEUE_DEPTH) - {1'b0, tail};

  always_comb begin
    push_en = 1'b0;
    push_data = b;
    if (cmd.copy_wr) begin
      push_en = 1'b1;
      push_data = ldata;
    end else if (cmd.apply && act == ActWrite && cls == ClsRaw) begin
      push_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_action;
      byte_r <= in_byte;
    end
    if (cmd.pop_rd) qdata <= queue_mem[tail];
    if (cmd.copy_rd) ldata <= line_mem[copy_idx];
    if (push_en) queue_mem[head] <= push_data;
    if (cmd.apply && act == ActWrite &&
        (cls == ClsStore || cls == ClsStoreCommit) &&
        ({1'b0, line_cnt} + (AW+1)'(1) < (AW+1)'(QUEUE_DEPTH)))
      line_mem[line_cnt] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      line_cnt <= '0;
      copy_idx <= '0;
      popped <= 1'b0;
      kind_r <= SigNone;
    end else begin
      if (push_en) begin
        head <= head_inc;
        if (head_inc == tail) tail <= ptr_inc(tail);
      end
      if (cmd.load) begin
        popped <= 1'b0;
        kind_r <= SigNone;
        copy_idx <= '0;
      end
      if (cmd.apply) begin
        if (act == ActPop && head != tail) begin
          tail <= ptr_inc(tail);
          popped <= 1'b1;
        end
        if (act == ActWrite) begin
          unique case (cls)
            ClsSignal: begin
              line_cnt <= '0;
              kind_r <= (foreground_group != 32'd0) ? kind : SigNone;
            end
            ClsErase: if (line_cnt != '0) line_cnt <= line_cnt - AW'(1);
            ClsKill: line_cnt <= '0;
            ClsStore, ClsStoreCommit:
              if ({1'b0, line_cnt} + (AW+1)'(1) < (AW+1)'(QUEUE_DEPTH))
                line_cnt <= line_cnt + AW'(1);
            default: ;
          endcase
        end
      end
      if (cmd.copy_wr) copy_idx <= copy_idx + AW'(1);
      if (cmd.copy_end) line_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_byte <= popped ? qdata : 8'd0;
      read_valid <= popped;
      signal_kind <= kind_r;
      signal_group <= (kind_r != SigNone) ? foreground_group : 32'd0;
      queued_count <= 10'(used);
      line_length <= 10'(line_cnt);
    end
  end
endmodule

// File: rtl/tld_controller.sv
module tld_controller import tld_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);
  typedef enum logic [2:0] {Idle, Apply, CopyRd, CopyWr, Finish} state_t;
  state_t state;
  logic   out_full;

  assign s_tready = (state == Idle) && (!out_full || m_tready);
  assign m_tvalid = out_full;

  always_comb begin
    cmd = '0;
    cmd.load = s_tvalid && s_tready;
    unique case (state)
      Apply: begin
        cmd.apply = 1'b1;
        cmd.pop_rd = 1'b1;
      end
      CopyRd: cmd.copy_rd = 1'b1;
      CopyWr: begin
        cmd.copy_wr = 1'b1;
        cmd.copy_end = stat.copy_last;
      end
      Finish: cmd.finish = !out_full || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      out_full <= 1'b0;
    end else begin
      if (cmd.finish) out_full <= 1'b1;
      else if (m_tready) out_full <= 1'b0;
      unique case (state)
        Idle: if (cmd.load) state <= Apply;
        Apply: begin
          if ((stat.action == ActFlush ||
               (stat.action == ActWrite &&
                (stat.cls == ClsEof || stat.cls == ClsStoreCommit)))
              && !(stat.line_empty && stat.cls != ClsStoreCommit))
            state <= CopyRd;
          else if (stat.action == ActWrite && stat.cls == ClsStoreCommit)
            state <= CopyRd;
          else
            state <= Finish;
        end
        CopyRd: state <= stat.line_empty ? Finish : CopyWr;
        CopyWr: state <= stat.copy_last ? Finish : CopyRd;
        Finish: if (cmd.finish) state <= Idle;
        default: state <= Idle;
      endcase
    end
  end
endmodule

// File: rtl/tld_checker.sv
module tld_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0] m_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_rv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0) else $error("rbyte");
  a_sig: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == 2'd0 |-> m_tdata[39:8] == 32'd0) else $error("grp");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("seq");
endmodule

bind terminal_line_discipline tld_checker u_chk (.*);

// File: verif/terminal_line_discipline_tb.sv
`timescale 1ns / 100ps

module terminal_line_discipline_tb;
  import tld_pkg::*;

  localparam int Depth = QueueDepthDefault;
  localparam int CycleLimit = 3000000;

  typedef struct {
    action_t    act;
    logic [7:0] data;
  } tty_op_t;

  typedef struct {
    logic [7:0]  rbyte;
    logic        rvalid;
    sig_t        kind;
    logic [31:0] group;
    logic [9:0]  qcount;
    logic [9:0]  llen;
  } tty_resp_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // in_byte[7:0]
  logic [1:0]  s_tuser;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready;
  // read_byte[7:0], signal_group[39:8], queued_count[49:40], line_length[59:50]
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;   // read_valid[0], signal_kind[2:1]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  terminal_line_discipline u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the line discipline: registers, ring and line buffer.
  logic [2:0]  sh_mode;
  logic [23:0] sh_sig;
  logic [23:0] sh_edit;
  logic [7:0]  sh_eol;
  logic [31:0] sh_group;
  logic [7:0]  sh_ring [Depth];
  logic [7:0]  sh_line [Depth];
  int unsigned sh_head, sh_tail, sh_len;

  tty_op_t   pending_ops[$];
  tty_resp_t expected_resps[$];
  tty_op_t   drv_op;

  int send_idle;
  int recv_idle;
  int fail_count;
  int resp_count;
  int sig_count;
  int pop_hits;
  int cycle_count;
  bit hold_go;
  bit hold_used = 1'b0;
  int hold_cnt = 0;

  task automatic shadow_push(input logic [7:0] b);
    int unsigned nxt;
    nxt = (sh_head + 1) % Depth;
    if (nxt == sh_tail) sh_tail = (sh_tail + 1) % Depth;
    sh_ring[sh_head] = b;
    sh_head = nxt;
  endtask

  task automatic line_commit();
    for (int i = 0; i < sh_len; i++) shadow_push(sh_line[i]);
    sh_len = 0;
  endtask

  // Work out the response the block owes for one accepted operation.
  task automatic predict_tty(input tty_op_t op, output tty_resp_t r);
    logic [7:0] b;
    sig_t k;
    r = '{8'h00, 1'b0, SigNone, 32'h0, 10'h0, 10'h0};
    case (op.act)
      ActWrite: begin
        b = op.data;
        k = SigNone;
        if (b == ChCr && sh_mode[0]) b = ChLf;
        if (sh_mode[1]) begin
          // first match wins: interrupt, suspend, quit
          if (b == sh_sig[7:0]) k = SigIntr;
          else if (b == sh_sig[23:16]) k = SigSusp;
          else if (b == sh_sig[15:8]) k = SigQuit;
        end
        if (k != SigNone) begin
          sh_len = 0;
          if (sh_group != 0) begin
            r.kind = k;
            r.group = sh_group;
          end
        end else if (!sh_mode[2]) begin
          shadow_push(b);
        end else if (b == sh_edit[7:0]) begin
          if (sh_len != 0) sh_len--;
        end else if (b == sh_edit[15:8]) begin
          sh_len = 0;
        end else if (b == sh_edit[23:16]) begin
          line_commit();
        end else begin
          if (sh_len + 1 < Depth) begin
            sh_line[sh_len] = b;
            sh_len++;
          end
          // a delimiter commits even when the line is too long to keep it
          if (b == ChLf || (sh_eol != 0 && b == sh_eol)) line_commit();
        end
      end
      ActPop: begin
        if (sh_tail != sh_head) begin
          r.rbyte = sh_ring[sh_tail];
          r.rvalid = 1'b1;
          sh_tail = (sh_tail + 1) % Depth;
        end
      end
      ActFlush: line_commit();
      default: ;
    endcase
    r.qcount = 10'((sh_head + Depth - sh_tail) % Depth);
    r.llen = 10'(sh_len);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: offer the next pending operation, hold it until accepted.
  always @(posedge clk) begin
    tty_resp_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_tty(drv_op, r);
        expected_resps.push_back(r);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
          drv_op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= drv_op.data;
          s_tuser <= drv_op.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down once it is started.
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= 400;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver: random stalls, held off while the long hold-off runs.
  always @(posedge clk) begin
    tty_resp_t e;
    logic [63:0] d;
    if (!rst && m_tvalid && m_tready) begin
      d = m_tdata;
      if (expected_resps.size() == 0) begin
        $error("response beat with nothing expected");
        fail_count++;
      end else begin
        e = expected_resps.pop_front();
        resp_count++;
        if (e.kind != SigNone) sig_count++;
        if (e.rvalid) pop_hits++;
        if (d[7:0] != e.rbyte) begin
          $error("read_byte exp %0h got %0h", e.rbyte, d[7:0]);
          fail_count++;
        end
        if (m_tuser[0] != e.rvalid) begin
          $error("read_valid exp %0b got %0b", e.rvalid, m_tuser[0]);
          fail_count++;
        end
        if (m_tuser[2:1] != e.kind) begin
          $error("signal_kind exp %0d got %0d", e.kind, m_tuser[2:1]);
          fail_count++;
        end
        if (d[39:8] != e.group) begin
          $error("signal_group exp %0h got %0h", e.group, d[39:8]);
          fail_count++;
        end
        if (d[49:40] != e.qcount) begin
          $error("queued_count exp %0d got %0d", e.qcount, d[49:40]);
          fail_count++;
        end
        if (d[59:50] != e.llen) begin
          $error("line_length exp %0d got %0d", e.llen, d[59:50]);
          fail_count++;
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0 || (hold_go && !hold_used)) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("terminal_line_discipline regression: fail");
      $finish;
    end
  end

  // Register write with setup and access phases; shadow copy follows at the access edge.
  task automatic reg_write(input reg_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegMode:  sh_mode = val[2:0];
      RegSig:   sh_sig = val[23:0];
      RegEdit:  sh_edit = val[23:0];
      RegEol:   sh_eol = val[7:0];
      RegGroup: sh_group = val;
      default: ;
    endcase
  endtask

  task automatic add_op(input action_t a, input logic [7:0] b);
    pending_ops.push_back('{a, b});
  endtask

  // Drain: wait until every operation is sent and answered.
  task automatic drain();
    while (pending_ops.size() > 0 || s_tvalid || expected_resps.size() > 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly line-shaped traffic: text, edit keys, delimiters, signals, pops.
  task automatic add_random(input int n);
    int sel;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      b = 8'($urandom_range(255));
      if (sel < 40) add_op(ActWrite, 8'($urandom_range(8'h20, 8'h7E)));
      else if (sel < 50) add_op(ActWrite, b);
      else if (sel < 56) add_op(ActWrite, sh_edit[8 * $urandom_range(2) +: 8]);
      else if (sel < 60) add_op(ActWrite, sh_sig[8 * $urandom_range(2) +: 8]);
      else if (sel < 66) add_op(ActWrite, ($urandom_range(1) != 0) ? ChCr : ChLf);
      else if (sel < 68) add_op(ActWrite, sh_eol);
      else if (sel < 90) add_op(ActPop, b);
      else if (sel < 96) add_op(ActFlush, b);
      else add_op(ActNone, b);
    end
  endtask

  task automatic random_setup();
    logic [2:0] m;
    m = 3'($urandom_range(7));
    // keep canonical mode common so lines get built and committed
    if ($urandom_range(3) != 0) m[2] = 1'b1;
    reg_write(RegMode, 32'(m));
    if ($urandom_range(2) == 0) reg_write(RegSig, $urandom);
    if ($urandom_range(2) == 0) reg_write(RegEdit, $urandom);
    reg_write(RegEol, ($urandom_range(1) != 0) ? 32'($urandom_range(255)) : 32'h0);
    reg_write(RegGroup, ($urandom_range(2) == 0) ? 32'h0 : $urandom);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 0;
    recv_idle = 0;
    fail_count = 0;
    resp_count = 0;
    sig_count = 0;
    pop_hits = 0;
    cycle_count = 0;
    hold_go = 1'b0;
    sh_mode = 3'd7;
    sh_sig = 24'h1A1C03;
    sh_edit = 24'h04157F;
    sh_eol = 8'h00;
    sh_group = 32'h0;
    sh_head = 0;
    sh_tail = 0;
    sh_len = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, group zero so signals only clear the line.
    add_op(ActPop, 8'h00);
    add_op(ActFlush, 8'h00);
    add_op(ActWrite, 8'h7F);
    add_op(ActWrite, 8'h00);
    add_op(ActWrite, 8'hFF);
    add_op(ActWrite, 8'h61);
    add_op(ActWrite, 8'h7F);
    add_op(ActWrite, 8'h62);
    add_op(ActWrite, 8'h03);
    add_op(ActWrite, 8'h63);
    add_op(ActWrite, 8'h15);
    add_op(ActWrite, 8'h64);
    add_op(ActWrite, 8'h04);
    add_op(ActWrite, 8'h04);
    add_op(ActWrite, ChCr);
    add_op(ActWrite, 8'h65);
    add_op(ActWrite, ChLf);
    add_op(ActNone, 8'hA5);
    add_op(ActPop, 8'h00);
    add_op(ActPop, 8'h00);
    drain();

    // Signal and edit roles on one character: interrupt wins; then suspend, quit, interrupt raised.
    reg_write(RegGroup, 32'hFFFF_FFFF);
    reg_write(RegSig, 32'h007F7F7F);
    reg_write(RegEdit, 32'h007F7F7F);
    reg_write(RegEol, 32'h0000002E);
    add_op(ActWrite, 8'h7F);
    add_op(ActWrite, 8'h41);
    add_op(ActWrite, 8'h2E);
    drain();
    reg_write(RegSig, 32'h001A1C03);
    reg_write(RegEdit, 32'h0004157F);
    add_op(ActWrite, 8'h1A);
    add_op(ActWrite, 8'h1C);
    add_op(ActWrite, 8'h03);
    drain();

    // Raw mode burst straight into the ring, then a few pops.
    reg_write(RegMode, 32'd0);
    for (int i = 0; i < 120; i++) add_op(ActWrite, 8'($urandom_range(255)));
    for (int i = 0; i < 8; i++) add_op(ActPop, 8'h00);
    drain();

    // Long canonical line committed by LF in one copy.
    reg_write(RegMode, 32'd7);
    for (int i = 0; i < 100; i++) add_op(ActWrite, 8'(8'h41 + (i % 26)));
    add_op(ActWrite, ChLf);
    add_op(ActPop, 8'h00);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    reg_write(RegSig, 32'h00FFFFFF);
    reg_write(RegEdit, 32'h00000000);
    add_random(60);
    hold_go = 1'b1;
    drain();

    // Random phases across idle patterns and register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 69; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 69; end
        default: begin send_idle = 16; recv_idle = 16; end
      endcase
      random_setup();
      add_random(25);
      drain();
    end
    send_idle = 0;
    recv_idle = 0;
    repeat (40) @(posedge clk);

    $display("covered %0d responses: %0d signals raised, %0d bytes popped", resp_count,
             sig_count, pop_hits);
    $display("raw burst, long line, shared role characters and idle patterns exercised");
    if (fail_count == 0) begin
      $display("terminal_line_discipline regression: pass");
    end else begin
      $display("terminal_line_discipline regression: fail");
    end
    $finish;
  end

endmodule
